>>> hdl/msp_pkg.sv
// Shared types, register codes and limits for the motor speed PID unit.
package msp_pkg;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_GAIN_P = 2'd1,
    REG_GAIN_I = 2'd2,
    REG_GAIN_D = 2'd3
  } reg_idx_t;

  localparam logic signed [15:0] SET_LIM        = 16'sd255;
  localparam logic signed [32:0] INT_LIM        = 33'sd32767;
  localparam logic        [7:0]  OUT_LIM_WIDE   = 8'd255;
  localparam logic        [7:0]  OUT_LIM_NARROW = 8'd100;
  localparam logic        [7:0]  ROUND_HALF     = 8'd128;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
  } gains_t;

  typedef struct packed {
    logic               active;
    logic               narrow;
    logic signed [16:0] err;
    logic signed [31:0] integ;
    logic signed [17:0] diff;
  } err_terms_t;

  typedef struct packed {
    logic               active;
    logic               narrow;
    logic signed [32:0] p_term;
    logic signed [47:0] i_term;
    logic signed [33:0] d_term;
  } pid_terms_t;

endpackage

>>> hdl/msp_err.sv
// Error stage: setpoint update, error, integral with saturation and the difference term.
module msp_err import msp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr_integ,
  input  logic               enable,
  input  logic               step,
  input  logic               load,
  input  logic               req,
  input  logic signed [15:0] setp,
  input  logic signed [15:0] vel,
  output err_terms_t         terms_r
);

  logic signed [31:0] integ_r, integ_nxt;
  logic signed [16:0] prev_r;
  logic signed [8:0]  target_r, target_nxt;
  logic signed [8:0]  setp_clamped;
  logic signed [16:0] err;
  logic signed [32:0] acc;
  logic signed [17:0] diff;
  err_terms_t         terms_nxt;

  always_comb begin
    if (setp > SET_LIM) begin
      setp_clamped = 9'(SET_LIM);
    end else if (setp < -SET_LIM) begin
      setp_clamped = 9'(-SET_LIM);
    end else begin
      setp_clamped = setp[8:0];
    end
    target_nxt = req ? setp_clamped : target_r;
    err = 17'(target_nxt) - 17'(vel);
    acc = 33'(integ_r) + 33'(err);
    if (req) begin
      // Saturate only at the 32-bit signed range.
      if (acc[32] != acc[31]) begin
        integ_nxt = acc[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
        integ_nxt = acc[31:0];
      end
    end else if (acc > INT_LIM) begin
      integ_nxt = 32'(INT_LIM);
    end else if (acc < -INT_LIM) begin
      integ_nxt = 32'(-INT_LIM);
    end else begin
      integ_nxt = acc[31:0];
    end
    diff = 18'(err) - 18'(prev_r);
    terms_nxt.active = enable;
    terms_nxt.narrow = req;
    terms_nxt.err    = err;
    terms_nxt.integ  = integ_nxt;
    terms_nxt.diff   = diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r  <= '0;
      prev_r   <= '0;
      target_r <= '0;
    end else if (clr_integ) begin
      integ_r <= '0;
    end else if (step) begin
      if (enable) begin
        integ_r  <= integ_nxt;
        prev_r   <= err;
        target_r <= target_nxt;
      end else begin
        integ_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms_r <= terms_nxt;
    end
  end

endmodule

>>> hdl/msp_mul.sv
// Product stage: the three gain multiplications, each registered.
module msp_mul import msp_pkg::*; (
  input  logic       clk,
  input  logic       load,
  input  err_terms_t terms,
  input  gains_t     gains,
  output pid_terms_t prods_r
);

  pid_terms_t prods_nxt;

  always_comb begin
    prods_nxt.active = terms.active;
    prods_nxt.narrow = terms.narrow;
    prods_nxt.p_term = 33'(terms.err) * 33'(gains.kp);
    prods_nxt.i_term = 48'(terms.integ) * 48'(gains.ki);
    prods_nxt.d_term = 34'(terms.diff) * 34'(gains.kd);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prods_r <= prods_nxt;
    end
  end

endmodule

>>> hdl/msp_out.sv
// Output stage: sum of terms, round half away from zero, clamp and result register.
module msp_out import msp_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  pid_terms_t        prods,
  output logic              active_r,
  output logic signed [8:0] drive_r
);

  logic signed [47:0] sum;
  logic               neg;
  logic        [47:0] mag;
  logic        [39:0] rnd;
  logic        [7:0]  lim;
  logic        [8:0]  mag_lim;
  logic signed [8:0]  drive_nxt;

  always_comb begin
    sum = 48'(prods.p_term) + prods.i_term + 48'(prods.d_term);
    neg = sum[47];
    mag = neg ? 48'(-sum) : 48'(sum);
    rnd = 40'((mag + 48'(ROUND_HALF)) >> 8);
    lim = prods.narrow ? OUT_LIM_NARROW : OUT_LIM_WIDE;
    if (rnd > 40'(lim)) begin
      mag_lim = 9'(lim);
    end else begin
      mag_lim = rnd[8:0];
    end
    if (!prods.active) begin
      drive_nxt = '0;
    end else begin
      drive_nxt = neg ? -$signed(mag_lim) : $signed(mag_lim);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      active_r <= prods.active;
      drive_r  <= drive_nxt;
    end
  end

endmodule

>>> hdl/motor_speed_pid_unit.sv
// Top level of the motor speed PID unit: handshakes, configuration and stage control.
//
// Input channel: in_valid with in_req_type, in_new_setpoint and in_velocity; a
// transaction completes at a clock edge with in_valid high and in_stall low.
// Every input transaction gives exactly one result on the out_ channel
// (out_active, out_drive), which completes with out_valid high and out_stall low.
// Configuration: cfg_index 0 is enable, 1..3 are gain_p, gain_i, gain_d (Q8.8);
// cfg_ready is always high. Write registers only while no transaction is in flight.
// Writing enable as 0 clears the integral at once.
// A result passes from the input transaction to out_valid through the input register,
// error stage, multiplier stage and output register. One transaction can be taken
// every cycle unless out_stall holds the pipeline; the rate is set by the error stage,
// where the integral and the last error are updated together.
// When out_stall is high, results back up stage by stage; in_stall rises only
// when all four stages hold a transaction. Synchronous reset (rst_n low) empties
// the pipeline and clears gains, enable, integral, last error and setpoint.
module motor_speed_pid_unit import msp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic signed [15:0] in_new_setpoint,
  input  logic signed [15:0] in_velocity,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_active,
  output logic signed [8:0] out_drive,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic        [1:0] cfg_index,
  input  logic       [15:0] cfg_data
);

  logic               enable_r;
  gains_t             gains_r;
  logic               s0_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  logic               req_r;
  logic signed [15:0] setp_r, vel_r;
  logic               rdy_out, rdy2, rdy1, rdy0;
  logic               cfg_wr, clr_integ;
  err_terms_t         terms;
  pid_terms_t         prods;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign clr_integ = cfg_wr && (reg_idx_t'(cfg_index) == REG_ENABLE) && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      gains_r  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE: enable_r   <= cfg_data[0];
        REG_GAIN_P: gains_r.kp <= $signed(cfg_data);
        REG_GAIN_I: gains_r.ki <= $signed(cfg_data);
        REG_GAIN_D: gains_r.kd <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // A stage can take a new transaction when it is empty or its content moves on.
  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy2     = !s2_valid_r || rdy_out;
  assign rdy1     = !s1_valid_r || rdy2;
  assign rdy0     = !s0_valid_r || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0) begin
        s0_valid_r <= in_valid;
      end
      if (rdy1) begin
        s1_valid_r <= s0_valid_r;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      req_r  <= in_req_type;
      setp_r <= in_new_setpoint;
      vel_r  <= in_velocity;
    end
  end

  msp_err u_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_integ (clr_integ),
    .enable    (enable_r),
    .step      (s0_valid_r && rdy1),
    .load      (rdy1),
    .req       (req_r),
    .setp      (setp_r),
    .vel       (vel_r),
    .terms_r   (terms)
  );

  msp_mul u_mul (
    .clk     (clk),
    .load    (rdy2),
    .terms   (terms),
    .gains   (gains_r),
    .prods_r (prods)
  );

  msp_out u_out (
    .clk      (clk),
    .load     (rdy_out),
    .prods    (prods),
    .active_r (out_active),
    .drive_r  (out_drive)
  );

  assign out_valid = out_valid_r;

endmodule

>>> dv/tb.sv
// Self-checking testbench for motor_speed_pid_unit: directed table, integral windup runs, random phases.
module tb;
  import msp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic               active;
    logic signed [8:0]  drive;
  } pid_result_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    reg_idx_t           idx;
    logic        [15:0] data;
    logic               req;
    logic signed [15:0] setp;
    logic signed [15:0] vel;
    bit                 fixed;
    logic               active;
    logic signed [8:0]  drive;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_req_type;
  logic signed [15:0] in_new_setpoint;
  logic signed [15:0] in_velocity;
  logic              out_valid;
  logic              out_stall;
  logic              out_active;
  logic signed [8:0] out_drive;
  logic              cfg_valid;
  logic              cfg_ready;
  logic        [1:0] cfg_index;
  logic       [15:0] cfg_data;

  // Predictor state, kept at the widths of the block.
  logic               loop_on;
  gains_t             gains;
  logic signed [31:0] integ_acc;
  logic signed [16:0] last_err;
  logic signed [8:0]  speed_target;

  pid_result_t drive_expected[$];
  int          errors;
  int unsigned cycles;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;

  // Typed expectations appear only where the value is plain from the gains at hand.
  plan_row_t plan [0:29] = '{
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sd1234,  1'b1, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b1, 16'sd300,   16'sd0,     1'b1, 1'b0, 9'sd0},
    '{ROW_REG,  REG_ENABLE, 16'h0001, 1'b0, 16'sd0,     16'sd0,     1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sd0,     1'b1, 1'b1, 9'sd0},
    '{ROW_REG,  REG_GAIN_P, 16'h7FFF, 1'b0, 16'sd0,     16'sd0,     1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sh8000,  1'b1, 1'b1, 9'sd255},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sh7FFF,  1'b1, 1'b1, -9'sd255},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b1, 16'sh7FFF,  16'sd0,     1'b1, 1'b1, 9'sd100},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b1, 16'sh8000,  16'sd0,     1'b1, 1'b1, -9'sd100},
    '{ROW_REG,  REG_GAIN_P, 16'h8000, 1'b0, 16'sd0,     16'sd0,     1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b1, 16'sd255,   16'sd0,     1'b1, 1'b1, -9'sd100},
    '{ROW_REG,  REG_GAIN_P, 16'h0080, 1'b0, 16'sd0,     16'sd0,     1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sd254,   1'b1, 1'b1, 9'sd1},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sd256,   1'b1, 1'b1, -9'sd1},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sd252,   1'b1, 1'b1, 9'sd2},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sd258,   1'b1, 1'b1, -9'sd2},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b1, -16'sd255,  -16'sd255,  1'b1, 1'b1, 9'sd0},
    '{ROW_REG,  REG_GAIN_I, 16'h7FFF, 1'b0, 16'sd0,     16'sd0,     1'b0, 1'b0, 9'sd0},
    '{ROW_REG,  REG_GAIN_D, 16'h8000, 1'b0, 16'sd0,     16'sd0,     1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sh8000,  1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sh8000,  1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sh7FFF,  1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b1, 16'sd100,   16'sd90,    1'b0, 1'b0, 9'sd0},
    '{ROW_REG,  REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sd0,     1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     16'sd5,     1'b1, 1'b0, 9'sd0},
    '{ROW_REG,  REG_ENABLE, 16'hFFFF, 1'b0, 16'sd0,     16'sd0,     1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b0, 16'sd0,     -16'sd7,    1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b1, 16'sd255,   16'sh7FFF,  1'b0, 1'b0, 9'sd0},
    '{ROW_REG,  REG_GAIN_I, 16'h8000, 1'b0, 16'sd0,     16'sd0,     1'b0, 1'b0, 9'sd0},
    '{ROW_ITEM, REG_ENABLE, 16'h0000, 1'b1, -16'sd300,  16'sh7FFF,  1'b0, 1'b0, 9'sd0}
  };

  motor_speed_pid_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_new_setpoint (in_new_setpoint),
    .in_velocity     (in_velocity),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_active      (out_active),
    .out_drive       (out_drive),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void apply_reg(reg_idx_t idx, logic [15:0] d);
    case (idx)
      REG_ENABLE: begin
        loop_on = d[0];
        if (!d[0]) integ_acc = '0;
      end
      REG_GAIN_P: gains.kp = d;
      REG_GAIN_I: gains.ki = d;
      REG_GAIN_D: gains.kd = d;
      default: ;
    endcase
  endfunction

  function automatic pid_result_t pid_predict(logic req, logic signed [15:0] setp,
                                              logic signed [15:0] vel);
    pid_result_t res;
    longint      tgt, err, acc, prev, integ, total, mag, r, lim;
    res = '0;
    if (!loop_on) begin
      integ_acc = '0;
      return res;
    end
    if (req) begin
      tgt = setp;
      speed_target = 9'(clip(tgt, -longint'(SET_LIM), longint'(SET_LIM)));
    end
    tgt = speed_target;
    err = tgt - longint'(vel);
    integ = integ_acc;
    acc = integ + err;
    if (req) begin
      integ = clip(acc, SAT_LO, SAT_HI);
      lim = OUT_LIM_NARROW;
    end else begin
      integ = clip(acc, -longint'(INT_LIM), longint'(INT_LIM));
      lim = OUT_LIM_WIDE;
    end
    integ_acc = 32'(integ);
    prev = last_err;
    total = err * longint'(gains.kp) + integ * longint'(gains.ki)
          + (err - prev) * longint'(gains.kd);
    mag = (total < 0) ? -total : total;
    mag = (mag + longint'(ROUND_HALF)) >>> 8;
    r = (total < 0) ? -mag : mag;
    r = clip(r, -lim, lim);
    last_err = 17'(err);
    res.active = 1'b1;
    res.drive = r[8:0];
    return res;
  endfunction

  // Called just after a falling edge; returns at the falling edge after acceptance
  // without touching in_valid, so the caller decides what follows.
  task automatic push_sample(logic req, logic signed [15:0] setp, logic signed [15:0] vel,
                             bit fixed = 1'b0, pid_result_t fixed_res = '0);
    pid_result_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_new_setpoint <= setp;
    in_velocity     <= vel;
    do @(posedge clk); while (in_stall);
    res = pid_predict(req, setp, vel);
    drive_expected.push_back(fixed ? fixed_res : res);
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (drive_expected.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    int v;
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: begin
        v = int'($urandom_range(1200)) - 600;
        return v[15:0];
      end
    endcase
  endfunction

  task automatic retune();
    logic [15:0] en_word;
    en_word = 16'($urandom);
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, pick_gain());
    write_reg(REG_GAIN_D, pick_gain());
    // Occasionally drop enable first so the integral starts from zero.
    if ($urandom_range(2) == 0) write_reg(REG_ENABLE, {en_word[15:1], 1'b0});
    en_word[0] = ($urandom_range(7) != 0);
    write_reg(REG_ENABLE, en_word);
  endtask

  // Drives the same large error for a run of samples so the integral grows one way.
  task automatic wind_integral(logic signed [15:0] setp, logic signed [15:0] vel);
    for (int k = 0; k < 60; k++) push_sample(1'b1, setp, vel);
  endtask

  function automatic void note_mismatch(string what, longint expv, longint actv);
    errors++;
    if (errors <= 30)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expv, actv);
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    pid_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_expected.size() == 0) begin
        note_mismatch("unexpected transaction, active", -1, out_active);
      end else begin
        want = drive_expected.pop_front();
        if (out_active !== want.active) note_mismatch("active", want.active, out_active);
        if (out_drive !== want.drive) note_mismatch("drive", want.drive, out_drive);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    pid_result_t typed;
    logic        req;
    logic [31:0] setp_w, vel_w;
    int          pick;

    idle_tab = '{0, 47, 0, 29};
    stall_tab = '{0, 0, 47, 29};
    errors = 0;
    cycles = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_new_setpoint = '0;
    in_velocity = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    loop_on = 1'b0;
    gains = '0;
    integ_acc = '0;
    last_err = '0;
    speed_target = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        quiesce();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        typed.active = plan[i].active;
        typed.drive = plan[i].drive;
        push_sample(plan[i].req, plan[i].setp, plan[i].vel, plan[i].fixed, typed);
      end
    end

    // Runs of the largest error in each direction, then a sample with the stored
    // setpoint, which pulls the integral back into the tight clamp.
    quiesce();
    write_reg(REG_GAIN_P, 16'h0100);
    write_reg(REG_GAIN_I, 16'h0001);
    write_reg(REG_GAIN_D, 16'h0000);
    write_reg(REG_ENABLE, 16'h0001);
    wind_integral(16'sh7FFF, 16'sh8000);
    push_sample(1'b0, 16'sd0, 16'sd0);
    quiesce();
    write_reg(REG_ENABLE, 16'h0000);
    write_reg(REG_ENABLE, 16'h0001);
    wind_integral(16'sh8000, 16'sh7FFF);
    push_sample(1'b0, 16'sd0, -16'sd3);

    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = idle_tab[ph];
      out_stall_pct = stall_tab[ph];
      for (int n = 0; n < 270; n++) begin
        if (n % 100 == 0) begin
          quiesce();
          retune();
        end
        req = 1'($urandom_range(1));
        setp_w = $urandom;
        vel_w = $urandom;
        pick = $urandom_range(3);
        if (pick != 0) begin
          setp_w = int'($urandom_range(600)) - 300;
          vel_w = int'($urandom_range(400)) - 200;
        end
        push_sample(req, setp_w[15:0], vel_w[15:0]);
      end
    end

    quiesce();
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> motor_speed_pid_unit.f
hdl/msp_pkg.sv
hdl/msp_err.sv
hdl/msp_mul.sv
hdl/msp_out.sv
hdl/motor_speed_pid_unit.sv
dv/tb.sv
